[rtl/core/fgt_pkg.sv]
// Shared types and constants of the flow gap tracker.
package fgt_pkg;

  localparam int TIME_W   = 64;
  localparam int IDX_W    = 10;
  // One table entry: analysis-active flag above the last-seen time.
  localparam int ENTRY_W  = TIME_W + 1;

  localparam logic [TIME_W-1:0] GAP_THRESHOLD_RESET = 64'd1000000;

  localparam logic OP_PACKET = 1'b0;
  localparam logic OP_DONE   = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [IDX_W-1:0]  flow_index;
    logic [TIME_W-1:0] now_ns;
  } in_item_t;

  typedef struct packed {
    logic             start_analysis;
    logic             gap_seen;
    logic [IDX_W-1:0] flow_index_out;
  } out_item_t;

endpackage

[rtl/core/fgt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module fgt_ram #(
  parameter int WIDTH = 65,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/fgt_fifo.sv]
// Small generic queue with full and empty flags.
module fgt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[rtl/core/fgt_front.sv]
// Front end: takes items, folds the flow index into the table and queues commands.
module fgt_front #(
  parameter int TABLE_ENTRIES = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  fgt_pkg::in_item_t   in_data,
  output logic                in_full,
  input  logic                clearing,
  input  logic                cmd_pop,
  output logic [$clog2(TABLE_ENTRIES)+$bits(fgt_pkg::in_item_t)-1:0] cmd_data,
  output logic                cmd_empty
);

  import fgt_pkg::*;

  localparam int AW    = $clog2(TABLE_ENTRIES);
  localparam int CMD_W = AW + $bits(in_item_t);
  // Remainder workspace; 7 restoring steps cover quotients up to 127.
  localparam int RW    = 24;
  localparam int STEPS = 7;

  logic [RW-1:0]    rem;
  in_item_t         item;
  logic [CMD_W-1:0] cmd_in;
  logic             q_full;

  always_comb begin
    logic [RW-1:0] sub_c;
    rem = RW'(in_data.flow_index);
    for (int k = STEPS - 1; k >= 0; k--) begin
      sub_c = RW'(TABLE_ENTRIES) << k;
      if (rem >= sub_c) begin
        rem = rem - sub_c;
      end
    end
  end

  always_comb begin
    item            = in_data;
    item.flow_index = rem[IDX_W-1:0];
  end

  assign cmd_in  = {rem[AW-1:0], item};
  assign in_full = q_full || clearing;

  fgt_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (2)
  ) u_cmd_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push && !in_full),
    .push_data (cmd_in),
    .full      (q_full),
    .pop       (cmd_pop),
    .pop_data  (cmd_data),
    .empty     (cmd_empty)
  );

endmodule

[rtl/core/fgt_back.sv]
// Back end: clears the table after reset, then runs one read-modify-write per command.
module fgt_back #(
  parameter int TABLE_ENTRIES = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [fgt_pkg::TIME_W-1:0]          gap_threshold,
  input  logic                                cmd_empty,
  input  logic [$clog2(TABLE_ENTRIES)+$bits(fgt_pkg::in_item_t)-1:0] cmd_data,
  output logic                                cmd_pop,
  output logic                                ram_we,
  output logic [$clog2(TABLE_ENTRIES)-1:0]    ram_waddr,
  output logic [fgt_pkg::ENTRY_W-1:0]         ram_wdata,
  output logic                                ram_re,
  output logic [$clog2(TABLE_ENTRIES)-1:0]    ram_raddr,
  input  logic [fgt_pkg::ENTRY_W-1:0]         ram_rdata,
  input  logic                                res_full,
  output logic                                res_push,
  output fgt_pkg::out_item_t                  res_data,
  output logic                                clearing
);

  import fgt_pkg::*;

  localparam int AW    = $clog2(TABLE_ENTRIES);
  localparam int CMD_W = AW + $bits(in_item_t);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [AW-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic [CMD_W-1:0] cmd_r, cmd_nxt;

  logic [AW-1:0]     cur_idx;
  in_item_t          cur_item;
  logic [TIME_W-1:0] last_time;
  logic              active;
  logic [TIME_W-1:0] idle_time;
  logic              gap;
  logic              start;

  assign cur_idx   = cmd_r[CMD_W-1 -: AW];
  assign cur_item  = in_item_t'(cmd_r[$bits(in_item_t)-1:0]);
  assign last_time = ram_rdata[TIME_W-1:0];
  assign active    = ram_rdata[TIME_W];
  assign idle_time = cur_item.now_ns - last_time;
  assign gap       = (cur_item.operation == OP_PACKET) && (idle_time > gap_threshold);
  assign start     = gap && !active;
  assign clearing  = (state_r == ST_CLEAR);

  always_comb begin
    res_data.start_analysis = start;
    res_data.gap_seen       = gap;
    res_data.flow_index_out = cur_item.flow_index;
  end

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    cmd_nxt     = cmd_r;
    cmd_pop     = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = cur_idx;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = cmd_data[CMD_W-1 -: AW];
    res_push    = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        if (clr_cnt_r == AW'(TABLE_ENTRIES - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop   = 1'b1;
          ram_re    = 1'b1;
          cmd_nxt   = cmd_data;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!res_full) begin
          ram_we   = 1'b1;
          res_push = 1'b1;
          if (cur_item.operation == OP_PACKET) begin
            ram_wdata = {active || start, cur_item.now_ns};
          end else begin
            ram_wdata = {1'b0, last_time};
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

endmodule

[rtl/core/flow_gap_tracker.sv]
// Top level of the flow gap tracker: per-flow inactivity gap detection.
//
// Input channel: in_data is taken at an edge with in_push high and in_full low.
//   operation OP_PACKET updates the flow's last-seen time and tests the gap;
//   OP_DONE clears the flow's analysis-active flag.
// Result channel: one result per item, in order. The oldest result sits on
//   out_data while out_empty is low and leaves at an edge with out_pop high.
// Config channel: cfg_data is the gap threshold, written when cfg_valid and
//   cfg_ready are high; cfg_ready is always high. Write only while idle.
// Path: an accepted item passes the command queue, the back end's table read and
//   the result queue before its result shows on out_data.
// Pacing: the back end takes one item at a time through its table sequence (read
//   the entry, then write it back) and pops the next command only after that.
// Reset: rst_n is synchronous. Afterwards the back end zeroes the table, one
//   entry a cycle, from entry 0 to TABLE_ENTRIES-1; in_full stays high meanwhile.
// Stall: if out_pop is held low the two-entry result queue fills, the back
//   end waits, and the command queue fills until in_full rises.
module flow_gap_tracker #(
  parameter int TABLE_ENTRIES = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  input  fgt_pkg::in_item_t          in_data,
  output logic                       in_full,
  output logic                       out_empty,
  input  logic                       out_pop,
  output fgt_pkg::out_item_t         out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [fgt_pkg::TIME_W-1:0] cfg_data
);

  import fgt_pkg::*;

  localparam int AW    = $clog2(TABLE_ENTRIES);
  localparam int CMD_W = AW + $bits(in_item_t);
  localparam int RES_W = $bits(out_item_t);

  // gap threshold register
  logic [TIME_W-1:0] gap_threshold_r, gap_threshold_nxt;

  // front to back command queue
  logic [CMD_W-1:0] cmd_data;
  logic             cmd_empty;
  logic             cmd_pop;
  logic             clearing;

  // table port
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  // back end to result queue
  logic       res_full;
  logic       res_push;
  out_item_t  res_data;
  logic [RES_W-1:0] res_head;

  assign cfg_ready         = 1'b1;
  assign gap_threshold_nxt = (cfg_valid && cfg_ready) ? cfg_data : gap_threshold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_threshold_r <= GAP_THRESHOLD_RESET;
    end else begin
      gap_threshold_r <= gap_threshold_nxt;
    end
  end

  fgt_front #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .clearing  (clearing),
    .cmd_pop   (cmd_pop),
    .cmd_data  (cmd_data),
    .cmd_empty (cmd_empty)
  );

  fgt_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .gap_threshold (gap_threshold_r),
    .cmd_empty     (cmd_empty),
    .cmd_data      (cmd_data),
    .cmd_pop       (cmd_pop),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .ram_re        (ram_re),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata),
    .res_full      (res_full),
    .res_push      (res_push),
    .res_data      (res_data),
    .clearing      (clearing)
  );

  // flow table: {analysis active, last-seen time} per entry
  fgt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // result queue parts the back end from the receiver
  fgt_fifo #(
    .WIDTH (RES_W),
    .DEPTH (2)
  ) u_res_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_data),
    .full      (res_full),
    .pop       (out_pop),
    .pop_data  (res_head),
    .empty     (out_empty)
  );

  assign out_data = out_item_t'(res_head);

endmodule

[rtl/core/fgt_checker.sv]
// Port-level checker for the flow gap tracker, bound to the top level.
module fgt_checker #(
  parameter int TABLE_ENTRIES = 1024
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_full,
  input logic                       out_empty,
  input logic                       out_pop,
  input fgt_pkg::out_item_t         out_data
);

  import fgt_pkg::*;

  // after reset no result waits and no item is taken while the table clears
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> out_empty && in_full)
    else $error("outputs not quiet after reset");

  // an analysis is only launched on a gap
  a_start_needs_gap: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (!out_data.start_analysis || out_data.gap_seen))
    else $error("start_analysis without gap_seen");

  // reported index lies within the table
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (32'(out_data.flow_index_out) < TABLE_ENTRIES))
    else $error("flow_index_out beyond table");

  // a waiting result holds until taken
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("waiting result changed");

endmodule

bind flow_gap_tracker fgt_checker #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_fgt_checker (.*);
